FILE: rtl/packbits_icns_encoder_defines.svh
// Assertion macros shared by the RTL files.
// Each macro expects clk and rst to be visible in the module that uses it.
`ifndef PACKBITS_ICNS_ENCODER_DEFINES_SVH
`define PACKBITS_ICNS_ENCODER_DEFINES_SVH

`ifndef ASSERT_OFF
`define PB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PB_ASSERT(lbl, prop, msg)
`define PB_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: rtl/pbicns_pkg.sv
package pbicns_pkg;

  localparam int MAX_LITERAL_DEF = 128;
  localparam int MAX_RUN_DEF     = 130;

  localparam logic [7:0] MIN_RUN    = 8'd3;
  localparam logic [7:0] RUN_BIAS   = 8'd125;
  localparam logic [7:0] RUN_TOTAL  = 8'd2;
  localparam logic [3:0] ITEM_BYTES = 4'd8;

  // command queue depth and width of the per-block result index
  localparam int CMD_DEPTH = 4;
  localparam int PART_W    = 5;

  // one settled block, handed from the classifier to the emitter
  typedef struct packed {
    logic       is_run;
    logic [7:0] hdr;
    logic [7:0] value;
    logic [7:0] total;   // header plus body bytes
    logic       last;    // final block caused by its input byte
  } cmd_t;

  // address bits of the literal ring: room for two full literal blocks
  function automatic int ring_aw(input int max_lit);
    return $clog2(2 * ((max_lit + 8) >> 3));
  endfunction

endpackage

FILE: rtl/pbicns_in_if.sv
interface pbicns_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, data_byte, end_of_buffer, input ready);
  modport sink (input valid, data_byte, end_of_buffer, output ready);
endinterface

FILE: rtl/pbicns_out_if.sv
interface pbicns_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_0;
  logic [7:0] byte_1;
  logic [7:0] byte_2;
  logic [7:0] byte_3;
  logic [7:0] byte_4;
  logic [7:0] byte_5;
  logic [7:0] byte_6;
  logic [7:0] byte_7;
  logic [3:0] byte_count;
  logic       end_of_block;
  logic       last_of_run;

  modport source (
    output valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6, byte_7,
           byte_count, end_of_block, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6, byte_7,
           byte_count, end_of_block, last_of_run,
    output ready
  );
endinterface

FILE: rtl/packbits_icns_encoder.sv
// PackBits encoder, greedy variant for icns image planes.
// raw (sink): one byte per transfer; end_of_buffer on the last byte of a buffer
//   flushes every pending block.
// enc (source): one result per transfer, up to eight encoded bytes from byte_0
//   upward; end_of_block marks the last result of a block, last_of_run the last
//   result caused by one input byte.
// Throughput: one byte per cycle while the command queue and literal ring have room.
//   A byte carrying end_of_buffer holds raw.ready low while the lookahead and open
//   blocks drain; with a maximum run of 3 a run that closes a literal also stalls raw.
// Emitter: one result a cycle unless enc.ready stalls; a 128-byte literal is 17 results.
// Path: a block's first result follows the transfer that settles it through the
//   command queue, then the registered literal ring read.
// Stalls: when enc.ready is low the result register holds; the 4-entry command
//   queue and a literal ring of at least two full blocks let raw keep flowing
//   until they fill.
// Reset: synchronous; clears all runs, lookahead and queues. No clearing pass.
module packbits_icns_encoder
  import pbicns_pkg::*;
#(
  parameter int MAX_LITERAL = MAX_LITERAL_DEF,
  parameter int MAX_RUN     = MAX_RUN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  pbicns_in_if.sink     raw,
  pbicns_out_if.source  enc
);

  localparam int AW = ring_aw(MAX_LITERAL);
  localparam int PW = AW + 1;

  cmd_t          cmd;
  cmd_t          head;
  logic          cmd_push;
  logic          fifo_full;
  logic          fifo_empty;
  logic          pop;
  logic [PW-1:0] rd_ptr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [2:0]    wr_lane;
  logic [7:0]    wr_data;

  pbicns_front #(
    .MAX_LITERAL (MAX_LITERAL),
    .MAX_RUN     (MAX_RUN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .raw       (raw),
    .fifo_full (fifo_full),
    .rd_ptr    (rd_ptr),
    .cmd       (cmd),
    .cmd_push  (cmd_push),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_lane   (wr_lane),
    .wr_data   (wr_data)
  );

  pbicns_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd),
    .full  (fifo_full),
    .pop   (pop),
    .dout  (head),
    .empty (fifo_empty)
  );

  pbicns_back #(
    .MAX_LITERAL (MAX_LITERAL)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .enc        (enc),
    .head       (head),
    .head_valid (!fifo_empty),
    .pop        (pop),
    .rd_ptr     (rd_ptr),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_lane    (wr_lane),
    .wr_data    (wr_data)
  );

endmodule

FILE: rtl/pbicns_front.sv
`include "packbits_icns_encoder_defines.svh"

module pbicns_front
  import pbicns_pkg::*;
#(
  parameter int MAX_LITERAL = MAX_LITERAL_DEF,
  parameter int MAX_RUN     = MAX_RUN_DEF,
  localparam int AW         = ring_aw(MAX_LITERAL),
  localparam int PW         = AW + 1
) (
  input  logic            clk,
  input  logic            rst,
  pbicns_in_if.sink       raw,
  input  logic            fifo_full,
  input  logic [PW-1:0]   rd_ptr,
  output cmd_t            cmd,
  output logic            cmd_push,
  output logic            wr_en,
  output logic [AW-1:0]   wr_addr,
  output logic [2:0]      wr_lane,
  output logic [7:0]      wr_data
);

  localparam int         RING_WORDS = 2 ** AW;
  localparam logic [7:0] MAX_LIT8   = 8'(MAX_LITERAL);
  localparam logic [7:0] MAX_RUN8   = 8'(MAX_RUN);

  logic [7:0]    run_value, run_value_next;
  logic [7:0]    run_length, run_length_next;
  logic [7:0]    la0, la0_next;
  logic [7:0]    la1, la1_next;
  logic [1:0]    la_count, la_count_next;
  logic [7:0]    lit_count, lit_count_next;
  logic [PW-1:0] base, base_next;
  logic          busy, busy_next;
  logic          flush, flush_next;

  logic [PW-1:0] front_end;
  logic [PW-1:0] used;
  logic          can_go;
  logic          accept;
  logic          op;
  logic          last_sel;
  logic [7:0]    wr_pos;
  logic [PW-1:0] wr_word;

  function automatic logic [7:0] words_of(input logic [7:0] count);
    return (count + 8'd8) >> 3;
  endfunction

  function automatic cmd_t make_lit(input logic [7:0] count, input logic last);
    cmd_t c;
    c.is_run = 1'b0;
    c.hdr    = count - 8'd1;
    c.value  = '0;
    c.total  = count + 8'd1;
    c.last   = last;
    return c;
  endfunction

  function automatic cmd_t make_run(input logic [7:0] len, input logic [7:0] value,
                                    input logic last);
    cmd_t c;
    c.is_run = 1'b1;
    c.hdr    = len + RUN_BIAS;
    c.value  = value;
    c.total  = RUN_TOTAL;
    c.last   = last;
    return c;
  endfunction

  // words held by the open literal plus blocks not yet read out
  assign front_end = base + ((lit_count == '0) ? '0 : PW'(words_of(lit_count)));
  assign used      = front_end - rd_ptr;
  assign can_go    = !fifo_full && (used < PW'(RING_WORDS));
  assign raw.ready = !busy && can_go;
  assign accept    = raw.valid && raw.ready;
  assign op        = busy && can_go;

  always_comb begin
    run_value_next  = run_value;
    run_length_next = run_length;
    la0_next        = la0;
    la1_next        = la1;
    la_count_next   = la_count;
    lit_count_next  = lit_count;
    base_next       = base;
    flush_next      = flush;
    cmd             = '0;
    cmd_push        = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_lane         = '0;
    wr_data         = '0;
    wr_pos          = '0;
    wr_word         = '0;
    last_sel        = 1'b0;

    if (accept) begin
      flush_next = raw.end_of_buffer;
      if (run_length != '0) begin
        if (raw.data_byte == run_value) begin
          run_length_next = run_length + 8'd1;
          if (run_length_next >= MAX_RUN8) begin
            cmd             = make_run(run_length_next, run_value, 1'b1);
            cmd_push        = 1'b1;
            run_length_next = '0;
          end
        end else begin
          cmd             = make_run(run_length, run_value, !raw.end_of_buffer);
          cmd_push        = 1'b1;
          run_length_next = '0;
          la0_next        = raw.data_byte;
          la_count_next   = 2'd1;
        end
      end else if (la_count < 2'd2) begin
        if (la_count == 2'd0) begin
          la0_next = raw.data_byte;
        end else begin
          la1_next = raw.data_byte;
        end
        la_count_next = la_count + 2'd1;
      end else if (la0 == la1 && la1 == raw.data_byte) begin
        if (lit_count != '0) begin
          // the run opened here always yields a later block on flush or when full
          cmd            = make_lit(lit_count,
                                    !(raw.end_of_buffer || (MIN_RUN >= MAX_RUN8)));
          cmd_push       = 1'b1;
          base_next      = base + PW'(words_of(lit_count));
          lit_count_next = '0;
        end
        run_value_next  = raw.data_byte;
        run_length_next = MIN_RUN;
        la_count_next   = 2'd0;
        if (lit_count == '0 && MIN_RUN >= MAX_RUN8) begin
          cmd             = make_run(MIN_RUN, raw.data_byte, 1'b1);
          cmd_push        = 1'b1;
          run_length_next = '0;
        end
      end else begin
        wr_pos         = lit_count + 8'd1;
        wr_word        = base + PW'(wr_pos >> 3);
        wr_en          = 1'b1;
        wr_addr        = wr_word[AW-1:0];
        wr_lane        = wr_pos[2:0];
        wr_data        = la0;
        lit_count_next = wr_pos;
        if (lit_count_next >= MAX_LIT8) begin
          cmd            = make_lit(lit_count_next, !raw.end_of_buffer);
          cmd_push       = 1'b1;
          base_next      = base + PW'(words_of(lit_count_next));
          lit_count_next = '0;
        end
        la0_next = la1;
        la1_next = raw.data_byte;
      end
    end else if (op) begin
      if (run_length != '0) begin
        cmd             = make_run(run_length, run_value,
                                   !(flush && (la_count != '0 || lit_count != '0)));
        cmd_push        = 1'b1;
        run_length_next = '0;
      end else if (flush && la_count != '0) begin
        // drain one held byte a cycle while queue and ring have room; the final one closes the literal
        last_sel       = (la_count == 2'd1);
        wr_pos         = lit_count + 8'd1;
        wr_word        = base + PW'(wr_pos >> 3);
        wr_en          = 1'b1;
        wr_addr        = wr_word[AW-1:0];
        wr_lane        = wr_pos[2:0];
        wr_data        = la0;
        lit_count_next = wr_pos;
        if (lit_count_next >= MAX_LIT8 || last_sel) begin
          cmd            = make_lit(lit_count_next, last_sel);
          cmd_push       = 1'b1;
          base_next      = base + PW'(words_of(lit_count_next));
          lit_count_next = '0;
        end
        la0_next      = la1;
        la_count_next = la_count - 2'd1;
      end else if (flush && lit_count != '0) begin
        cmd            = make_lit(lit_count, 1'b1);
        cmd_push       = 1'b1;
        base_next      = base + PW'(words_of(lit_count));
        lit_count_next = '0;
      end
    end

    if (accept || op) begin
      busy_next = (run_length_next != '0 && run_length_next >= MAX_RUN8) ||
                  (flush_next && (run_length_next != '0 || la_count_next != '0 ||
                                  lit_count_next != '0));
    end else begin
      busy_next = busy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length <= '0;
      la_count   <= '0;
      lit_count  <= '0;
      base       <= '0;
      busy       <= 1'b0;
      flush      <= 1'b0;
    end else begin
      run_length <= run_length_next;
      la_count   <= la_count_next;
      lit_count  <= lit_count_next;
      base       <= base_next;
      busy       <= busy_next;
      flush      <= flush_next && busy_next;
    end
  end

  always_ff @(posedge clk) begin
    run_value <= run_value_next;
    la0       <= la0_next;
    la1       <= la1_next;
  end

  `PB_ASSERT(a_run_alone, run_length != '0 |-> la_count == '0 && lit_count == '0, "run open with pending literal bytes")
  `PB_ASSERT(a_ring_bound, used <= PW'(RING_WORDS), "literal ring overrun")
  `PB_ASSERT(a_run_settled, !busy |-> run_length < MAX_RUN8, "full run left open while idle")

endmodule

FILE: rtl/pbicns_cmd_fifo.sv
module pbicns_cmd_fifo
  import pbicns_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  localparam int IW = $clog2(CMD_DEPTH);
  localparam int CW = $clog2(CMD_DEPTH + 1);

  cmd_t          slots [CMD_DEPTH];
  logic [IW-1:0] wr_idx;
  logic [IW-1:0] rd_idx;
  logic [CW-1:0] count;

  assign full  = (count == CW'(CMD_DEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= (wr_idx == IW'(CMD_DEPTH - 1)) ? '0 : wr_idx + IW'(1);
      end
      if (pop) begin
        rd_idx <= (rd_idx == IW'(CMD_DEPTH - 1)) ? '0 : rd_idx + IW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= din;
    end
  end

endmodule

FILE: rtl/pbicns_back.sv
`include "packbits_icns_encoder_defines.svh"

module pbicns_back
  import pbicns_pkg::*;
#(
  parameter int MAX_LITERAL = MAX_LITERAL_DEF,
  localparam int AW         = ring_aw(MAX_LITERAL),
  localparam int PW         = AW + 1
) (
  input  logic          clk,
  input  logic          rst,
  pbicns_out_if.source  enc,
  input  cmd_t          head,
  input  logic          head_valid,
  output logic          pop,
  output logic [PW-1:0] rd_ptr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [2:0]    wr_lane,
  input  logic [7:0]    wr_data
);

  localparam int RING_WORDS = 2 ** AW;

  // literal ring: each block starts on a word, byte lane 0 of its first word
  // is left for the header
  logic [7:0][7:0] mem [RING_WORDS];

  logic [PART_W-1:0] part;
  logic [7:0]        rem;
  logic [3:0]        cnt;
  logic              blk_end;
  logic              issue;

  logic              b_valid;
  logic              b_run;
  logic              b_first;
  logic [7:0]        b_hdr;
  logic [7:0]        b_value;
  logic [3:0]        b_cnt;
  logic              b_eob;
  logic              b_last;
  logic [7:0][7:0]   b_word;
  logic [7:0][7:0]   res;

  assign rem     = head.total - {part, 3'b000};
  assign blk_end = (rem <= {4'd0, ITEM_BYTES});
  assign cnt     = blk_end ? rem[3:0] : ITEM_BYTES;
  assign issue   = head_valid && (!b_valid || enc.ready);
  assign pop     = issue && blk_end;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr][wr_lane] <= wr_data;
    end
    if (issue) begin
      b_word <= mem[rd_ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      part    <= '0;
      rd_ptr  <= '0;
      b_valid <= 1'b0;
    end else begin
      if (issue) begin
        part    <= blk_end ? '0 : part + PART_W'(1);
        b_valid <= 1'b1;
        if (!head.is_run) begin
          rd_ptr <= rd_ptr + PW'(1);
        end
      end else if (enc.ready) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_run   <= head.is_run;
      b_first <= (part == '0);
      b_hdr   <= head.hdr;
      b_value <= head.value;
      b_cnt   <= cnt;
      b_eob   <= blk_end;
      b_last  <= head.last && blk_end;
    end
  end

  always_comb begin
    res = b_word;
    if (b_run) begin
      res[1] = b_value;
    end
    if (b_first) begin
      res[0] = b_hdr;
    end
    for (int k = 0; k < 8; k++) begin
      if (4'(k) >= b_cnt) begin
        res[k] = '0;
      end
    end
  end

  assign enc.valid        = b_valid;
  assign enc.byte_0       = res[0];
  assign enc.byte_1       = res[1];
  assign enc.byte_2       = res[2];
  assign enc.byte_3       = res[3];
  assign enc.byte_4       = res[4];
  assign enc.byte_5       = res[5];
  assign enc.byte_6       = res[6];
  assign enc.byte_7       = res[7];
  assign enc.byte_count   = b_cnt;
  assign enc.end_of_block = b_eob;
  assign enc.last_of_run  = b_last;

  `PB_ASSERT(a_rd_step, !$stable(rd_ptr) |-> $past(issue && !head.is_run), "ring pointer moved without a literal read")
  `PB_ASSERT(a_last_eob, b_valid && b_last |-> b_eob, "last result not at a block end")
  `PB_ASSERT(a_cnt_range, b_valid |-> b_cnt != '0 && b_cnt <= ITEM_BYTES, "bad byte count")

endmodule
